@@ rtl/core/pmrw_pkg.sv @@
// Package for the pattern memory register window: sizes, bank request and
// response types, and the fill pattern function.
// No dependencies.
package pmrw_pkg;

    localparam int REGION_BYTES = 1024;
    localparam int ADDR_W       = $clog2(REGION_BYTES);
    localparam int SUM_W        = ADDR_W + 1;
    localparam int LANES        = 4;
    localparam int ROWS         = REGION_BYTES / LANES;
    localparam int ROW_W        = ADDR_W - 2;

    localparam logic [31:0] LEN_WORD = 32'(REGION_BYTES);
    localparam logic [31:0] SIG_WORD = 32'h4b44554d ^ (32'h53 << 24) ^ (32'h4d << 16);
    localparam logic [7:0]  CHR_S    = 8'h53;
    localparam logic [7:0]  CHR_M    = 8'h4d;
    localparam logic [7:0]  CHR_K    = 8'h4b;
    localparam logic [7:0]  CHR_D    = 8'h44;
    localparam logic [7:0]  CHR_P    = 8'h50;
    localparam logic [7:0]  MULT     = 8'h3d;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef struct packed {
        logic             rd_en;
        logic             data_we;
        logic             flag_we;
        logic [ROW_W-1:0] row;
        logic [7:0]       wdata;
        logic             wflag;
    } bank_req_t;

    typedef struct packed {
        logic [7:0] data;
        logic       flag;
    } bank_rsp_t;

    function automatic logic [7:0] fill_byte(input logic [ADDR_W-1:0] o,
                                             input logic [31:0] inst);
        logic [7:0] r;
        case (o)
            ADDR_W'(0):  r = CHR_K;
            ADDR_W'(1):  r = CHR_D;
            ADDR_W'(2):  r = CHR_M;
            ADDR_W'(3):  r = CHR_P;
            ADDR_W'(4):  r = CHR_S;
            ADDR_W'(5):  r = CHR_M;
            ADDR_W'(6):  r = inst[7:0];
            ADDR_W'(7):  r = inst[15:8];
            ADDR_W'(8):  r = LEN_WORD[7:0];
            ADDR_W'(9):  r = LEN_WORD[15:8];
            ADDR_W'(10): r = LEN_WORD[23:16];
            ADDR_W'(11): r = LEN_WORD[31:24];
            ADDR_W'(12): r = SIG_WORD[7:0];
            ADDR_W'(13): r = SIG_WORD[15:8];
            ADDR_W'(14): r = SIG_WORD[23:16];
            ADDR_W'(15): r = SIG_WORD[31:24];
            default:
                r = 8'(o[7:0] * MULT) ^ 8'(o >> 8) ^ CHR_S ^ 8'(CHR_M << 1) ^ inst[7:0];
        endcase
        return r;
    endfunction

endpackage

@@ rtl/core/pmrw_bank.sv @@
// One byte lane of the window: data memory and written-flag memory,
// one row per cycle, registered read. Depends on pmrw_pkg.
module pmrw_bank
(
    input  logic                clk,
    input  pmrw_pkg::bank_req_t req,
    output pmrw_pkg::bank_rsp_t rsp
);

    logic [7:0] data_mem [pmrw_pkg::ROWS];
    logic       flag_mem [pmrw_pkg::ROWS];

    always_ff @(posedge clk)
    begin
        if (req.data_we)
        begin
            data_mem[req.row] <= req.wdata;
        end
        if (req.flag_we)
        begin
            flag_mem[req.row] <= req.wflag;
        end
        if (req.rd_en)
        begin
            rsp.data <= data_mem[req.row];
            rsp.flag <= flag_mem[req.row];
        end
    end

endmodule

@@ rtl/core/pattern_memory_register_window.sv @@
// Top level of the pattern memory register window: four byte-lane banks,
// access decode, clearing pass, result assembly. Depends on pmrw_pkg, pmrw_bank.
//
//  channel | handshake            | payload
//  in      | in_valid / in_stall  | cmd, byte_address, access_size, write_data
//  out     | out_valid / out_stall| read_data
//  cfg     | cfg_valid / cfg_ready| cfg_data (instance_number)
//
// Each item: bank read (or write) at accept, then byte assembly into the output
// register; one item in flight at a time. After reset a clearing pass zeroes
// the written flags through all ROWS = 256 rows, with in_stall high. A stalled
// result holds the block in ST_RESP; the bank read data stays put until the
// result is taken.
module pattern_memory_register_window
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        cmd,
    input  logic [pmrw_pkg::ADDR_W-1:0] byte_address,
    input  logic [2:0]                  access_size,
    input  logic [31:0]                 write_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [63:0]                 read_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [31:0]                 cfg_data
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RESP = 1'b1;

    logic                          state_reg, state_next;
    logic                          clearing_reg, clearing_next;
    logic [pmrw_pkg::ROW_W-1:0]    clr_reg, clr_next;
    logic [31:0]                   instance_reg;
    logic                          out_valid_reg, out_valid_next;
    logic [63:0]                   read_data_reg;

    logic                          cmd_reg;
    logic                          ok_reg;
    logic [pmrw_pkg::ADDR_W-1:0]   addr_reg;
    logic [2:0]                    size_reg;

    pmrw_pkg::bank_req_t           req [pmrw_pkg::LANES];
    pmrw_pkg::bank_rsp_t           rsp [pmrw_pkg::LANES];

    logic                          accept;
    logic                          acc_ok;
    logic                          load_out;
    logic [pmrw_pkg::ROW_W-1:0]    row;
    logic [1:0]                    lo;
    logic [31:0]                   assembled;
    logic [63:0]                   result;

    assign in_stall  = clearing_reg || (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;

    assign row = byte_address[pmrw_pkg::ADDR_W-1:2];
    assign lo  = byte_address[1:0];
    assign acc_ok = ((access_size == 3'd1) || (access_size == 3'd2) || (access_size == 3'd4))
                    && (({1'b0, byte_address} + pmrw_pkg::SUM_W'(access_size))
                        <= pmrw_pkg::SUM_W'(pmrw_pkg::REGION_BYTES));

    // Lane b holds byte (b - lo) of the access; lanes below lo sit in the next row.
    always_comb
    begin
        for (int b = 0; b < pmrw_pkg::LANES; b++)
        begin
            logic [1:0] idx;
            idx = 2'(b) - lo;
            req[b].row     = (2'(b) < lo) ? row + 1'b1 : row;
            req[b].rd_en   = accept && (cmd == pmrw_pkg::CMD_READ);
            req[b].data_we = accept && (cmd == pmrw_pkg::CMD_WRITE) && acc_ok
                             && ({1'b0, idx} < access_size);
            req[b].flag_we = req[b].data_we;
            req[b].wflag   = 1'b1;
            req[b].wdata   = write_data[8*idx +: 8];
            if (clearing_reg)
            begin
                req[b].row     = clr_reg;
                req[b].flag_we = 1'b1;
                req[b].wflag   = 1'b0;
            end
        end
    end

    for (genvar g = 0; g < pmrw_pkg::LANES; g++)
    begin : g_bank
        pmrw_bank u_bank
        (
            .clk (clk),
            .req (req[g]),
            .rsp (rsp[g])
        );
    end

    always_comb
    begin
        assembled = '0;
        for (int i = 0; i < pmrw_pkg::LANES; i++)
        begin
            logic [1:0]                  b;
            logic [pmrw_pkg::ADDR_W-1:0] off;
            logic [7:0]                  v;
            b   = addr_reg[1:0] + 2'(i);
            off = addr_reg + pmrw_pkg::ADDR_W'(i);
            v   = rsp[b].flag ? rsp[b].data : pmrw_pkg::fill_byte(off, instance_reg);
            if (3'(i) < size_reg)
            begin
                assembled[8*i +: 8] = v;
            end
        end
        if (cmd_reg == pmrw_pkg::CMD_WRITE)
        begin
            result = '0;
        end
        else if (!ok_reg)
        begin
            result = '1;
        end
        else
        begin
            result = {32'h0, assembled};
        end
    end

    assign load_out = (state_reg == ST_RESP) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next     = state_reg;
        clearing_next  = clearing_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg;
        if (clearing_reg)
        begin
            clr_next = clr_reg + 1'b1;
            if (clr_reg == pmrw_pkg::ROW_W'(pmrw_pkg::ROWS - 1))
            begin
                clearing_next = 1'b0;
            end
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            clearing_reg  <= 1'b1;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            instance_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clearing_reg  <= clearing_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                instance_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= cmd;
            ok_reg   <= acc_ok;
            addr_reg <= byte_address;
            size_reg <= access_size;
        end
        if (load_out)
        begin
            read_data_reg <= result;
        end
    end

endmodule

@@ rtl/core/pmrw_checker.sv @@
// Port-level checker for the pattern memory register window, bound to the
// top level. Depends on pmrw_pkg and pattern_memory_register_window.
module pmrw_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        cmd,
    input logic [2:0]                  access_size,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [63:0]                 read_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(read_data))
        else $error("stalled result changed");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("item accepted back to back");

    a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (cmd == pmrw_pkg::CMD_WRITE) && !out_valid
        |-> ##2 (out_valid && (read_data == 64'h0)))
        else $error("write result not zero");

    a_bad_size_read: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (cmd == pmrw_pkg::CMD_READ) && (access_size == 3'd3)
        && !out_valid |-> ##2 (out_valid && (read_data == '1)))
        else $error("bad size read not all ones");

endmodule

bind pattern_memory_register_window pmrw_checker u_pmrw_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .access_size  (access_size),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .read_data    (read_data)
);

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for pattern_memory_register_window: directed table, then random
// accesses in three stall phases, each checked against a byte-level shadow of the window.
// Depends on pmrw_pkg and the RTL top level.
module tb;

    localparam int          PHASE_ITEMS = 625;
    localparam logic [63:0] ALL_ONES    = 64'hffff_ffff_ffff_ffff;
    localparam logic [7:0]  TAG_K       = 8'h4b;
    localparam logic [7:0]  TAG_D       = 8'h44;
    localparam logic [7:0]  TAG_M       = 8'h4d;
    localparam logic [7:0]  TAG_P       = 8'h50;
    localparam logic [7:0]  TAG_S       = 8'h53;
    localparam logic [31:0] FILL_SIG    = 32'h4b44554d ^ (32'h53 << 24) ^ (32'h4d << 16);
    localparam logic [31:0] FILL_LEN    = 32'(pmrw_pkg::REGION_BYTES);

    typedef struct packed {
        logic                        is_write;
        logic [pmrw_pkg::ADDR_W-1:0] addr;
        logic [2:0]                  size;
        logic [31:0]                 wdata;
        logic                        typed;
        logic [63:0]                 want;
    } access_row_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic                        cmd = 1'b0;
    logic [pmrw_pkg::ADDR_W-1:0] byte_address = '0;
    logic [2:0]                  access_size = 3'd0;
    logic [31:0]                 write_data = 32'd0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic [63:0]                 read_data;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [31:0]                 cfg_data = 32'd0;

    // shadow of the window contents
    logic [7:0]                  shadow_bytes   [0:pmrw_pkg::REGION_BYTES-1];
    logic                        shadow_written [0:pmrw_pkg::REGION_BYTES-1];
    logic [31:0]                 inst_now = 32'd0;
    logic [pmrw_pkg::ADDR_W-1:0] recent_write_addr = '0;

    logic [63:0]       awaited_read_data [$];
    logic [63:0]       oldest_due;
    int                mismatches = 0;

    int                send_gap_pct = 0;
    int                rx_stall_pct = 0;
    logic              press_now = 1'b0;
    int                hold_left = 0;
    logic              hold_done = 1'b0;

    access_row_t       directed_rows [27];

    pattern_memory_register_window dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .byte_address (byte_address),
        .access_size  (access_size),
        .write_data   (write_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .read_data    (read_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [7:0] fill_pattern(input int unsigned o, input logic [31:0] inst);
        logic [31:0] mix;
        case (o)
            0:  return TAG_K;
            1:  return TAG_D;
            2:  return TAG_M;
            3:  return TAG_P;
            4:  return TAG_S;
            5:  return TAG_M;
            6:  return inst[7:0];
            7:  return inst[15:8];
            8, 9, 10, 11:   return 8'(FILL_LEN >> ((o - 8) * 8));
            12, 13, 14, 15: return 8'(FILL_SIG >> ((o - 12) * 8));
            default:
            begin
                mix = (o * 32'h3d) ^ (o >> 8) ^ 32'(TAG_S) ^ (32'(TAG_M) << 1) ^ inst;
                return mix[7:0];
            end
        endcase
    endfunction

    // applies one access to the shadow and returns the read_data it should produce
    function automatic logic [63:0] window_access(input logic wr,
                                                  input logic [pmrw_pkg::ADDR_W-1:0] a,
                                                  input logic [2:0] sz, input logic [31:0] d);
        logic [63:0] v;
        int unsigned o;
        int unsigned span;
        logic        ok;
        span = a + sz;
        ok = (sz == 3'd1 || sz == 3'd2 || sz == 3'd4) && (span <= pmrw_pkg::REGION_BYTES);
        v = 64'd0;
        if (wr == pmrw_pkg::CMD_WRITE)
        begin
            if (ok)
                for (int i = 0; i < sz; i++)
                begin
                    o = a + i;
                    shadow_bytes[o] = d[i*8 +: 8];
                    shadow_written[o] = 1'b1;
                end
            return 64'd0;
        end
        if (!ok)
            return ALL_ONES;
        for (int i = 0; i < sz; i++)
        begin
            o = a + i;
            v[i*8 +: 8] = shadow_written[o] ? shadow_bytes[o] : fill_pattern(o, inst_now);
        end
        return v;
    endfunction

    function automatic access_row_t random_access();
        access_row_t r;
        int unsigned pick;
        r = '0;
        r.is_write = ($urandom_range(99) < 45) ? pmrw_pkg::CMD_WRITE : pmrw_pkg::CMD_READ;
        pick = $urandom_range(99);
        if (pick < 30)
            r.size = 3'd1;
        else if (pick < 60)
            r.size = 3'd2;
        else if (pick < 90)
            r.size = 3'd4;
        else
            r.size = 3'($urandom_range(7));
        pick = $urandom_range(9);
        if (pick == 0)
            r.addr = pmrw_pkg::ADDR_W'($urandom_range(15));
        else if (pick == 1)
            r.addr = pmrw_pkg::ADDR_W'(pmrw_pkg::REGION_BYTES - $urandom_range(6, 1));
        else if (pick == 2 && r.is_write == pmrw_pkg::CMD_READ)
            r.addr = recent_write_addr;   // read back what was just written
        else
            r.addr = pmrw_pkg::ADDR_W'($urandom_range(pmrw_pkg::REGION_BYTES - 1));
        r.wdata = $urandom;
        if (r.is_write == pmrw_pkg::CMD_WRITE)
            recent_write_addr = r.addr;
        return r;
    endfunction

    task automatic issue_access(input access_row_t row);
        logic [63:0] model_val;
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        cmd          <= row.is_write;
        byte_address <= row.addr;
        access_size  <= row.size;
        write_data   <= row.wdata;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        model_val = window_access(row.is_write, row.addr, row.size, row.wdata);
        awaited_read_data.push_back(row.typed ? row.want : model_val);
    endtask

    // instance_number write, only with nothing in flight
    task automatic set_instance(input logic [31:0] v);
        in_valid <= 1'b0;
        while (awaited_read_data.size() != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        inst_now = v;
    endtask

    // receiver: random stalls, plus one long hold-off so the block backs up
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (press_now && !hold_done)
            begin
                hold_left = 80;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_read_data.size() == 0)
            begin
                $error("read_data expected none actual %h", read_data);
                mismatches++;
            end
            else
            begin
                oldest_due = awaited_read_data.pop_front();
                if (read_data !== oldest_due)
                begin
                    $error("read_data expected %h actual %h", oldest_due, read_data);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        for (int i = 0; i < pmrw_pkg::REGION_BYTES; i++)
        begin
            shadow_bytes[i] = 8'd0;
            shadow_written[i] = 1'b0;
        end
        directed_rows = '{
            '{pmrw_pkg::CMD_READ,  10'd0,    3'd4, 32'd0,        1'b1, 64'h504d444b},
            '{pmrw_pkg::CMD_READ,  10'd4,    3'd2, 32'd0,        1'b1, 64'h4d53},
            '{pmrw_pkg::CMD_READ,  10'd6,    3'd2, 32'd0,        1'b1, 64'hffff},
            '{pmrw_pkg::CMD_READ,  10'd8,    3'd4, 32'd0,        1'b1, 64'h400},
            '{pmrw_pkg::CMD_READ,  10'd12,   3'd4, 32'd0,        1'b1, 64'h1809554d},
            '{pmrw_pkg::CMD_READ,  10'd16,   3'd1, 32'd0,        1'b0, 64'd0},
            '{pmrw_pkg::CMD_READ,  10'd1020, 3'd4, 32'd0,        1'b0, 64'd0},
            '{pmrw_pkg::CMD_READ,  10'd1023, 3'd1, 32'd0,        1'b0, 64'd0},
            '{pmrw_pkg::CMD_READ,  10'd1021, 3'd4, 32'd0,        1'b1, ALL_ONES},
            '{pmrw_pkg::CMD_READ,  10'd1023, 3'd2, 32'd0,        1'b1, ALL_ONES},
            '{pmrw_pkg::CMD_READ,  10'd0,    3'd3, 32'd0,        1'b1, ALL_ONES},
            '{pmrw_pkg::CMD_READ,  10'd0,    3'd0, 32'd0,        1'b1, ALL_ONES},
            '{pmrw_pkg::CMD_READ,  10'd8,    3'd5, 32'd0,        1'b1, ALL_ONES},
            '{pmrw_pkg::CMD_READ,  10'd8,    3'd6, 32'd0,        1'b1, ALL_ONES},
            '{pmrw_pkg::CMD_READ,  10'd8,    3'd7, 32'd0,        1'b1, ALL_ONES},
            '{pmrw_pkg::CMD_WRITE, 10'd0,    3'd4, 32'hdeadbeef, 1'b1, 64'd0},
            '{pmrw_pkg::CMD_READ,  10'd0,    3'd4, 32'd0,        1'b1, 64'hdeadbeef},
            '{pmrw_pkg::CMD_WRITE, 10'd1023, 3'd1, 32'hffffffff, 1'b1, 64'd0},
            '{pmrw_pkg::CMD_READ,  10'd1022, 3'd2, 32'd0,        1'b0, 64'd0},
            '{pmrw_pkg::CMD_WRITE, 10'd5,    3'd4, 32'h87654321, 1'b1, 64'd0},
            '{pmrw_pkg::CMD_READ,  10'd4,    3'd4, 32'd0,        1'b0, 64'd0},
            '{pmrw_pkg::CMD_WRITE, 10'd1022, 3'd4, 32'hffffffff, 1'b1, 64'd0},
            '{pmrw_pkg::CMD_READ,  10'd1020, 3'd4, 32'd0,        1'b0, 64'd0},
            '{pmrw_pkg::CMD_WRITE, 10'd32,   3'd3, 32'h55aa55aa, 1'b1, 64'd0},
            '{pmrw_pkg::CMD_READ,  10'd32,   3'd4, 32'd0,        1'b0, 64'd0},
            '{pmrw_pkg::CMD_WRITE, 10'd512,  3'd7, 32'd0,        1'b1, 64'd0},
            '{pmrw_pkg::CMD_READ,  10'd510,  3'd4, 32'd0,        1'b0, 64'd0}
        };
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        send_gap_pct = 6;
        rx_stall_pct = 76;
        set_instance(32'hffff_ffff);
        foreach (directed_rows[k])
            issue_access(directed_rows[k]);
        set_instance($urandom);
        repeat (PHASE_ITEMS)
            issue_access(random_access());

        send_gap_pct = 76;
        rx_stall_pct = 6;
        set_instance(32'd0);
        repeat (PHASE_ITEMS)
            issue_access(random_access());

        send_gap_pct = 0;
        rx_stall_pct = 0;
        set_instance($urandom);
        press_now = 1'b1;
        repeat (PHASE_ITEMS)
            issue_access(random_access());

        in_valid <= 1'b0;
        while (awaited_read_data.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/pmrw_pkg.sv
rtl/core/pmrw_bank.sv
rtl/core/pattern_memory_register_window.sv
rtl/core/pmrw_checker.sv
bench/tb.sv
